/* rtl/hbs_pkg.sv */
// Shared types, codes and default sizes for the heightmap bounds and sampler.
package hbs_pkg;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int CMD_W    = 2;
	localparam int POS_W    = 9;
	localparam int COORD_W  = 10;
	localparam int HEIGHT_W = 8;
	localparam int SAMPLE_W = 17;
	localparam int SVAL_W   = 24;
	localparam int CFG_W    = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WINDOW = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] MAP_SIZE_RST = 10'd512;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [POS_W-1:0]    col_a;
		logic [POS_W-1:0]    row_a;
		logic [POS_W-1:0]    col_b;
		logic [POS_W-1:0]    row_b;
		logic [HEIGHT_W-1:0] height_in;
		logic [SAMPLE_W-1:0] sample_x;
		logic [SAMPLE_W-1:0] sample_y;
	} req_item_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] min_height;
		logic [HEIGHT_W-1:0] max_height;
		logic [SVAL_W-1:0]   sample_value;
		logic                window_ok;
	} rsp_item_t;

	typedef struct packed {
		logic       clr;
		logic       issue;
		logic [1:0] corner;
	} interp_ctl_t;

endpackage

/* rtl/hbs_if.sv */
// Request and result channel interfaces with valid/ready handshake.
interface hbs_req_if;
	import hbs_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface hbs_rsp_if;
	import hbs_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/heightmap_bounds_and_bilinear_sampler_unit.sv */
// Heightmap store with widened-window min/max queries and bilinear sampling.
// One item is handled at a time through the single read port of the height
// memory: a texel write is stored as it is accepted, a window query walks every
// texel of the widened clamped window (an empty window skips the walk), and
// a sample query reads the four corner texels, then weights and accumulates
// them. A finished result waits in the output register while the next
// item is taken. The memory is not cleared: read only texels written before.
module heightmap_bounds_and_bilinear_sampler_unit #(
	parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hbs_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hbs_req_if.sink                       req,
	hbs_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [hbs_pkg::CFG_W-1:0]     cfg_data
);
	import hbs_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ACC_W  = HEIGHT_W + 2 * FRAC_BITS;
	localparam int CMP_W  = (SAMPLE_W > COORD_W + FRAC_BITS) ? SAMPLE_W : COORD_W + FRAC_BITS;
	localparam int SH_L   = (2 * FRAC_BITS >= 16) ? 0 : 16 - 2 * FRAC_BITS;
	localparam int SH_R   = (2 * FRAC_BITS >= 16) ? 2 * FRAC_BITS - 16 : 0;
	localparam int EXT_W  = ACC_W + 16;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WSET   = 3'd1;
	localparam logic [2:0] ST_WIN    = 3'd2;
	localparam logic [2:0] ST_WDRAIN = 3'd3;
	localparam logic [2:0] ST_SSET   = 3'd4;
	localparam logic [2:0] ST_SRD    = 3'd5;
	localparam logic [2:0] ST_SDRAIN = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0]           state_q;
	logic [CFG_W-1:0]     map_width_q;
	logic [CFG_W-1:0]     map_height_q;
	logic [COORD_W-1:0]   w_eff;
	logic [COORD_W-1:0]   h_eff;
	logic [COORD_W-1:0]   wm1;
	logic [COORD_W-1:0]   hm1;

	logic [HEIGHT_W-1:0]  height_mem [DEPTH];
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [HEIGHT_W-1:0]  rd_data_q;

	logic                 accept;
	logic [COORD_W-1:0]   x0_c;
	logic [COORD_W-1:0]   x1_c;
	logic [COORD_W-1:0]   y0_c;
	logic [COORD_W-1:0]   y1_c;
	logic [POS_W-1:0]     ca_dec;
	logic [POS_W-1:0]     ra_dec;
	logic [CMP_W-1:0]     xmax;
	logic [CMP_W-1:0]     ymax;
	logic [CMP_W-1:0]     sxw;
	logic [CMP_W-1:0]     syw;
	logic [CMP_W-1:0]     px;
	logic [CMP_W-1:0]     py;

	logic [COORD_W-1:0]   x0_q;
	logic [COORD_W-1:0]   x1_q;
	logic [COORD_W-1:0]   y0_q;
	logic [COORD_W-1:0]   y1_q;
	logic [COORD_W-1:0]   x_q;
	logic [COORD_W-1:0]   y_q;
	logic                 ok_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    row_base_q;
	logic                 rd_pend_s1;
	logic [HEIGHT_W-1:0]  lo_q;
	logic [HEIGHT_W-1:0]  hi_q;
	logic                 win_mode_q;

	logic [COORD_W-1:0]   ix_q;
	logic [COORD_W-1:0]   iy_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic                 dx_q;
	logic                 dy_q;
	logic [1:0]           k_q;
	logic [ADDR_W-1:0]    samp_addr;
	interp_ctl_t          ictl;
	logic [ACC_W-1:0]     acc;
	logic [EXT_W-1:0]     acc_ext;
	logic [SVAL_W-1:0]    sval;

	logic                 out_valid_q;
	rsp_item_t            out_q;
	logic                 out_free;

	always_comb begin
		if (map_width_q == '0) begin
			w_eff = COORD_W'(1);
		end else if (32'(map_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = COORD_W'(MAX_WIDTH);
		end else begin
			w_eff = map_width_q;
		end
		if (map_height_q == '0) begin
			h_eff = COORD_W'(1);
		end else if (32'(map_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = COORD_W'(MAX_HEIGHT);
		end else begin
			h_eff = map_height_q;
		end
		wm1 = w_eff - COORD_W'(1);
		hm1 = h_eff - COORD_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_SIZE_RST;
			map_height_q <= MAP_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		ca_dec = (req.payload.col_a == '0) ? '0 : req.payload.col_a - POS_W'(1);
		ra_dec = (req.payload.row_a == '0) ? '0 : req.payload.row_a - POS_W'(1);
		x0_c = ({1'b0, ca_dec} < wm1) ? {1'b0, ca_dec} : wm1;
		y0_c = ({1'b0, ra_dec} < hm1) ? {1'b0, ra_dec} : hm1;
		x1_c = ((COORD_W'(req.payload.col_b) + COORD_W'(1)) < wm1)
			? COORD_W'(req.payload.col_b) + COORD_W'(1) : wm1;
		y1_c = ((COORD_W'(req.payload.row_b) + COORD_W'(1)) < hm1)
			? COORD_W'(req.payload.row_b) + COORD_W'(1) : hm1;
		xmax = CMP_W'(wm1) << FRAC_BITS;
		ymax = CMP_W'(hm1) << FRAC_BITS;
		sxw  = CMP_W'(req.payload.sample_x);
		syw  = CMP_W'(req.payload.sample_y);
		px   = (sxw > xmax) ? xmax : sxw;
		py   = (syw > ymax) ? ymax : syw;
	end

	always_comb begin
		mem_we    = accept && (req.payload.cmd == CMD_WRITE)
			&& (COORD_W'(req.payload.col_a) <= wm1) && (COORD_W'(req.payload.row_a) <= hm1);
		mem_waddr = ADDR_W'(32'(req.payload.row_a) * MAX_WIDTH + 32'(req.payload.col_a));
		samp_addr = row_base_q + ADDR_W'(k_q[0] & dx_q)
			+ ((k_q[1] & dy_q) ? ADDR_W'(MAX_WIDTH) : '0);
		mem_raddr = (state_q == ST_SRD) ? samp_addr : addr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			height_mem[mem_waddr] <= req.payload.height_in;
		end
		rd_data_q <= height_mem[mem_raddr];
	end

	always_comb begin
		ictl.clr    = (state_q == ST_SSET);
		ictl.issue  = (state_q == ST_SRD);
		ictl.corner = k_q;
	end

	hbs_interp #(
		.FRAC_BITS(FRAC_BITS)
	) u_interp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ictl),
		.fx    (fx_q),
		.fy    (fy_q),
		.texel (rd_data_q),
		.acc   (acc)
	);

	always_comb begin
		acc_ext = EXT_W'(acc);
		sval    = SVAL_W'((acc_ext << SH_L) >> SH_R);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_WIN);
			case (state_q)
				ST_IDLE: begin
					if (accept && req.payload.cmd == CMD_WINDOW) begin
						state_q <= ST_WSET;
					end else if (accept && req.payload.cmd == CMD_SAMPLE) begin
						state_q <= ST_SSET;
					end
				end
				ST_WSET:   state_q <= ok_q ? ST_WIN : ST_FIN;
				ST_WIN: begin
					if (x_q == x1_q && y_q == y1_q) begin
						state_q <= ST_WDRAIN;
					end
				end
				ST_WDRAIN: state_q <= ST_FIN;
				ST_SSET:   state_q <= ST_SRD;
				ST_SRD: begin
					if (k_q == 2'd3) begin
						state_q <= ST_SDRAIN;
					end
				end
				ST_SDRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q       <= x0_c;
			x1_q       <= x1_c;
			y0_q       <= y0_c;
			y1_q       <= y1_c;
			ok_q       <= (x0_c <= x1_c) && (y0_c <= y1_c);
			win_mode_q <= (req.payload.cmd == CMD_WINDOW);
			ix_q       <= COORD_W'(px >> FRAC_BITS);
			iy_q       <= COORD_W'(py >> FRAC_BITS);
			fx_q       <= px[FRAC_BITS-1:0];
			fy_q       <= py[FRAC_BITS-1:0];
		end
		case (state_q)
			ST_WSET: begin
				row_base_q <= ADDR_W'(32'(y0_q) * MAX_WIDTH);
				addr_q     <= ADDR_W'(32'(y0_q) * MAX_WIDTH + 32'(x0_q));
				x_q        <= x0_q;
				y_q        <= y0_q;
				lo_q       <= '1;
				hi_q       <= '0;
			end
			ST_WIN: begin
				if (x_q == x1_q) begin
					x_q        <= x0_q;
					y_q        <= y_q + COORD_W'(1);
					row_base_q <= row_base_q + ADDR_W'(MAX_WIDTH);
					addr_q     <= row_base_q + ADDR_W'(MAX_WIDTH) + ADDR_W'(x0_q);
				end else begin
					x_q    <= x_q + COORD_W'(1);
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
			ST_SSET: begin
				row_base_q <= ADDR_W'(32'(iy_q) * MAX_WIDTH + 32'(ix_q));
				dx_q       <= (ix_q != wm1);
				dy_q       <= (iy_q != hm1);
				k_q        <= 2'd0;
			end
			ST_SRD: begin
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
		if (rd_pend_s1) begin
			if (rd_data_q < lo_q) begin
				lo_q <= rd_data_q;
			end
			if (rd_data_q > hi_q) begin
				hi_q <= rd_data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (win_mode_q) begin
				out_q.min_height   <= ok_q ? lo_q : '0;
				out_q.max_height   <= ok_q ? hi_q : '0;
				out_q.sample_value <= '0;
				out_q.window_ok    <= ok_q;
			end else begin
				out_q.min_height   <= '0;
				out_q.max_height   <= '0;
				out_q.sample_value <= sval;
				out_q.window_ok    <= 1'b0;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.payload.cmd == CMD_WINDOW || req.payload.cmd == CMD_SAMPLE)
		|=> !req.ready)
		else $error("query accepted without leaving idle");

	a_walk_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WIN |-> x_q >= x0_q && x_q <= x1_q && y_q >= y0_q && y_q <= y1_q)
		else $error("window walk left the clamped window");

	a_read_pend_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == ST_WIN || state_q == ST_WDRAIN)
		else $error("min/max update outside a window walk");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.window_ok |-> rsp.payload.sample_value == '0)
		else $error("window result carries a sample value");

endmodule

/* rtl/hbs_interp.sv */
// Bilinear weight product and multiply-accumulate over the four corner texels.
module hbs_interp #(
	parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hbs_pkg::interp_ctl_t         ctl,
	input  logic [FRAC_BITS-1:0]         fx,
	input  logic [FRAC_BITS-1:0]         fy,
	input  logic [hbs_pkg::HEIGHT_W-1:0] texel,
	output logic [hbs_pkg::HEIGHT_W+2*FRAC_BITS-1:0] acc
);
	import hbs_pkg::*;

	localparam int WT_W   = FRAC_BITS + 1;
	localparam int WP_W   = 2 * FRAC_BITS + 1;
	localparam int ACC_W  = HEIGHT_W + 2 * FRAC_BITS;
	localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_BITS;

	logic [WT_W-1:0]  wx;
	logic [WT_W-1:0]  wy;
	logic [WP_W-1:0]  wprod_s1;
	logic             pend_s1;
	logic [ACC_W-1:0] acc_q;

	always_comb begin
		wx = ctl.corner[0] ? {1'b0, fx} : ONE - {1'b0, fx};
		wy = ctl.corner[1] ? {1'b0, fy} : ONE - {1'b0, fy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		wprod_s1 <= WP_W'(wx) * WP_W'(wy);
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (pend_s1) begin
			acc_q <= acc_q + ACC_W'(texel) * ACC_W'(wprod_s1);
		end
	end

	assign acc = acc_q;

endmodule

/* tb/testbench.sv */
// Self-checking bench for the heightmap sampler: directed table, then random items per map size.
module testbench;
	import hbs_pkg::*;

	localparam int MAP_COLS = DEF_MAX_WIDTH;
	localparam int MAP_ROWS = DEF_MAX_HEIGHT;
	localparam int FRAC = DEF_FRAC_BITS;
	localparam int ONE = 1 << FRAC;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 1525 / PHASES;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		req_item_t            item;
		bit                   typed;
		rsp_item_t            want;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	hbs_req_if req_ch();
	hbs_rsp_if rsp_ch();

	heightmap_bounds_and_bilinear_sampler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	logic [HEIGHT_W-1:0] heights [MAP_COLS*MAP_ROWS];
	bit                  written [MAP_COLS*MAP_ROWS];
	logic [CFG_W-1:0]    cols_reg = MAP_SIZE_RST;
	logic [CFG_W-1:0]    rows_reg = MAP_SIZE_RST;
	rsp_item_t           awaited [$];
	bit                  eager;
	int                  mismatches;
	int                  items_done;
	int                  texel_writes;
	int                  window_queries;
	int                  empty_windows;
	int                  sample_queries;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int span_of(logic [CFG_W-1:0] raw, int lim);
		if (raw < 1) return 1;
		if (raw > lim) return lim;
		return int'(raw);
	endfunction

	function automatic int map_cols();
		return span_of(cols_reg, MAP_COLS);
	endfunction

	function automatic int map_rows();
		return span_of(rows_reg, MAP_ROWS);
	endfunction

	function automatic bit window_span(req_item_t it, output int x0, x1, y0, y1);
		int w = map_cols();
		int h = map_rows();
		x0 = (it.col_a == 0) ? 0 : int'(it.col_a) - 1;
		y0 = (it.row_a == 0) ? 0 : int'(it.row_a) - 1;
		x1 = int'(it.col_b) + 1;
		y1 = int'(it.row_b) + 1;
		if (x0 > w - 1) x0 = w - 1;
		if (y0 > h - 1) y0 = h - 1;
		if (x1 > w - 1) x1 = w - 1;
		if (y1 > h - 1) y1 = h - 1;
		return (x0 <= x1) && (y0 <= y1);
	endfunction

	function automatic void sample_corners(req_item_t it, output int ix, ix2, iy, iy2, fx, fy);
		int xmax = (map_cols() - 1) << FRAC;
		int ymax = (map_rows() - 1) << FRAC;
		int px = (int'(it.sample_x) > xmax) ? xmax : int'(it.sample_x);
		int py = (int'(it.sample_y) > ymax) ? ymax : int'(it.sample_y);
		ix = px >> FRAC;
		iy = py >> FRAC;
		fx = px & (ONE - 1);
		fy = py & (ONE - 1);
		ix2 = (ix + 1 > map_cols() - 1) ? map_cols() - 1 : ix + 1;
		iy2 = (iy + 1 > map_rows() - 1) ? map_rows() - 1 : iy + 1;
	endfunction

	function automatic rsp_item_t window_bounds(req_item_t it);
		rsp_item_t r = '0;
		int x0, x1, y0, y1;
		logic [HEIGHT_W-1:0] lo = '1;
		logic [HEIGHT_W-1:0] hi = '0;
		logic [HEIGHT_W-1:0] z;
		if (window_span(it, x0, x1, y0, y1)) begin
			for (int y = y0; y <= y1; y++) begin
				for (int x = x0; x <= x1; x++) begin
					z = heights[y*MAP_COLS + x];
					if (z > hi) hi = z;
					if (z < lo) lo = z;
				end
			end
			r.min_height = lo;
			r.max_height = hi;
			r.window_ok = 1'b1;
		end
		return r;
	endfunction

	function automatic rsp_item_t bilinear_height(req_item_t it);
		rsp_item_t r = '0;
		int ix, ix2, iy, iy2, fx, fy;
		longint unsigned a, b, c, d, acc;
		sample_corners(it, ix, ix2, iy, iy2, fx, fy);
		a = heights[iy*MAP_COLS + ix];
		b = heights[iy*MAP_COLS + ix2];
		c = heights[iy2*MAP_COLS + ix];
		d = heights[iy2*MAP_COLS + ix2];
		acc = a * (ONE - fx) * (ONE - fy) + b * fx * (ONE - fy)
			+ c * (ONE - fx) * fy + d * fx * fy;
		if (2 * FRAC >= 16) begin
			acc = acc >> (2 * FRAC - 16);
		end else begin
			acc = acc << (16 - 2 * FRAC);
		end
		r.sample_value = acc[SVAL_W-1:0];
		return r;
	endfunction

	function automatic req_item_t random_item();
		req_item_t it;
		it.cmd = CMD_W'($urandom);
		it.col_a = POS_W'($urandom);
		it.row_a = POS_W'($urandom);
		it.col_b = POS_W'($urandom);
		it.row_b = POS_W'($urandom);
		it.height_in = HEIGHT_W'($urandom);
		it.sample_x = SAMPLE_W'($urandom);
		it.sample_y = SAMPLE_W'($urandom);
		return it;
	endfunction

	function automatic int pick_pos(int size, int hot);
		int roll = $urandom_range(0, 99);
		int p;
		if (roll < 70) begin
			p = hot + $urandom_range(0, 24) - 12;
		end else if (roll < 78) begin
			p = $urandom_range(0, POS_MAX);
		end else if (roll < 90) begin
			p = size - 1;
		end else begin
			p = $urandom_range(0, 1) * POS_MAX;
		end
		if (p < 0) p = 0;
		if (p > POS_MAX) p = POS_MAX;
		return p;
	endfunction

	function automatic int far_corner(int a);
		int b;
		if ($urandom_range(0, 5) == 0) begin
			b = a - $urandom_range(1, 5);
		end else begin
			b = a + $urandom_range(0, 9);
		end
		if (b < 0) b = 0;
		if (b > POS_MAX) b = POS_MAX;
		return b;
	endfunction

	function automatic int sample_coord(int size, int hot);
		int roll = $urandom_range(0, 99);
		if (roll < 75) return (pick_pos(size, hot) << FRAC) | $urandom_range(0, ONE - 1);
		if (roll < 82) return pick_pos(size, hot) << FRAC;
		if (roll < 92) return $urandom_range(0, SAMPLE_MAX);
		if (roll < 96) return (size - 1) << FRAC;
		return SAMPLE_MAX;
	endfunction

	function automatic int idle_len();
		int roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic stim_row_t op(logic [CMD_W-1:0] cmd, int ca, int ra, int cb, int rb,
			int hv, int sx, int sy, bit typed = 1'b0, int mn = 0, int mx = 0,
			int sv = 0, bit ok = 1'b0);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.item.cmd = cmd;
		r.item.col_a = POS_W'(ca);
		r.item.row_a = POS_W'(ra);
		r.item.col_b = POS_W'(cb);
		r.item.row_b = POS_W'(rb);
		r.item.height_in = HEIGHT_W'(hv);
		r.item.sample_x = SAMPLE_W'(sx);
		r.item.sample_y = SAMPLE_W'(sy);
		r.typed = typed;
		r.want.min_height = HEIGHT_W'(mn);
		r.want.max_height = HEIGHT_W'(mx);
		r.want.sample_value = SVAL_W'(sv);
		r.want.window_ok = ok;
		r.idx = '0;
		r.val = '0;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.item = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.idx = idx;
		r.val = CFG_W'(val);
		return r;
	endfunction

	task automatic issue(input req_item_t it, input bit typed, input rsp_item_t want);
		int gap;
		rsp_item_t r;
		req_ch.payload <= it;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		case (it.cmd)
			CMD_WRITE: begin
				if (it.col_a < map_cols() && it.row_a < map_rows()) begin
					heights[it.row_a*MAP_COLS + it.col_a] = it.height_in;
					written[it.row_a*MAP_COLS + it.col_a] = 1'b1;
					texel_writes++;
				end
			end
			CMD_WINDOW: begin
				r = typed ? want : window_bounds(it);
				awaited.push_back(r);
				window_queries++;
				if (!r.window_ok) empty_windows++;
			end
			CMD_SAMPLE: begin
				awaited.push_back(typed ? want : bilinear_height(it));
				sample_queries++;
			end
			default: ;
		endcase
		items_done++;
		gap = eager ? 0 : idle_len();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAP_WIDTH) begin
			cols_reg = val;
		end else begin
			rows_reg = val;
		end
	endtask

	// fill every unwritten texel that a query is about to read
	task automatic cover_region(input int x0, input int x1, input int y0, input int y1);
		req_item_t it;
		for (int y = y0; y <= y1; y++) begin
			for (int x = x0; x <= x1; x++) begin
				if (!written[y*MAP_COLS + x]) begin
					it = random_item();
					it.cmd = CMD_WRITE;
					it.col_a = POS_W'(x);
					it.row_a = POS_W'(y);
					issue(it, 1'b0, '0);
				end
			end
		end
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			int run;
			stall = idle_len();
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		rsp_item_t got;
		rsp_item_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (awaited.size() == 0) begin
				$error("unexpected result item %p", got);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (got.min_height !== want.min_height) begin
					$error("min_height: expected %0d, got %0d", want.min_height, got.min_height);
					mismatches++;
				end
				if (got.max_height !== want.max_height) begin
					$error("max_height: expected %0d, got %0d", want.max_height, got.max_height);
					mismatches++;
				end
				if (got.sample_value !== want.sample_value) begin
					$error("sample_value: expected %0d, got %0d", want.sample_value,
						got.sample_value);
					mismatches++;
				end
				if (got.window_ok !== want.window_ok) begin
					$error("window_ok: expected %0d, got %0d", want.window_ok, got.window_ok);
					mismatches++;
				end
			end
		end
	end

	initial begin
		stim_row_t directed [27];
		logic [CFG_W-1:0] phase_cols [PHASES];
		logic [CFG_W-1:0] phase_rows [PHASES];
		req_item_t it;
		int x0, x1, y0, y1, ix, ix2, iy, iy2, fx, fy;
		int roll, goal, w, h, hot_c, hot_r, pos;

		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		phase_cols = '{10'd512, 10'd0, 10'd1023, 10'd1, 10'd512, 10'd9, 10'd33, 10'd0};
		phase_rows = '{10'd512, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd6, 10'd17, 10'd0};
		directed = '{
			op(CMD_WRITE, 510, 510, 0, 0, 17, 0, 0),
			op(CMD_WRITE, 511, 510, 0, 0, 255, 0, 0),
			op(CMD_WRITE, 510, 511, 0, 0, 0, 0, 0),
			op(CMD_WRITE, 511, 511, 0, 0, 200, 0, 0),
			op(CMD_SAMPLE, 0, 0, 0, 0, 0, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 0, 0, 200 << 16, 1'b0),
			op(CMD_WINDOW, 511, 511, 511, 511, 0, 0, 0, 1'b1, 0, 255, 0, 1'b1),
			reg_row(REG_MAP_WIDTH, 4),
			reg_row(REG_MAP_HEIGHT, 3),
			op(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0),
			op(CMD_WRITE, 1, 0, 0, 0, 10, 0, 0),
			op(CMD_WRITE, 2, 0, 0, 0, 20, 0, 0),
			op(CMD_WRITE, 3, 0, 0, 0, 30, 0, 0),
			op(CMD_WRITE, 0, 1, 0, 0, 40, 0, 0),
			op(CMD_WRITE, 1, 1, 0, 0, 50, 0, 0),
			op(CMD_WRITE, 2, 1, 0, 0, 60, 0, 0),
			op(CMD_WRITE, 3, 1, 0, 0, 70, 0, 0),
			op(CMD_WRITE, 0, 2, 0, 0, 80, 0, 0),
			op(CMD_WRITE, 1, 2, 0, 0, 90, 0, 0),
			op(CMD_WRITE, 2, 2, 0, 0, 100, 0, 0),
			op(CMD_WRITE, 3, 2, 0, 0, 255, 0, 0),
			op(CMD_WRITE, 4, 0, 0, 0, 99, 0, 0),
			op(CMD_WRITE, 0, 3, 0, 0, 99, 0, 0),
			op(CMD_UNUSED, 511, 511, 511, 511, 255, SAMPLE_MAX, SAMPLE_MAX),
			op(CMD_WINDOW, 0, 0, 511, 511, 0, 0, 0, 1'b1, 0, 255, 0, 1'b1),
			op(CMD_WINDOW, 511, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0),
			op(CMD_SAMPLE, 0, 0, 0, 0, 0, 'h180, 'h080),
			op(CMD_SAMPLE, 0, 0, 0, 0, 0, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 0, 0, 255 << 16, 1'b0)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				set_reg(directed[i].idx, directed[i].val);
			end else begin
				issue(directed[i].item, directed[i].typed, directed[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				phase_cols[p] = CFG_W'($urandom_range(0, 1023));
				phase_rows[p] = CFG_W'($urandom_range(0, 1023));
			end
			set_reg(REG_MAP_WIDTH, phase_cols[p]);
			set_reg(REG_MAP_HEIGHT, phase_rows[p]);
			w = map_cols();
			h = map_rows();
			hot_c = $urandom_range(0, w - 1);
			hot_r = $urandom_range(0, h - 1);
			eager = ($urandom_range(0, 3) == 0);
			goal = items_done + ITEMS_PER_PHASE;
			while (items_done < goal) begin
				roll = $urandom_range(0, 99);
				it = random_item();
				if (roll < 6) begin
					if (roll < 3 && w < MAP_COLS) begin
						it.cmd = CMD_WRITE;
						it.col_a = POS_W'($urandom_range(w, POS_MAX));
					end else if (roll < 3 && h < MAP_ROWS) begin
						it.cmd = CMD_WRITE;
						it.row_a = POS_W'($urandom_range(h, POS_MAX));
					end else begin
						it.cmd = CMD_UNUSED;
					end
					issue(it, 1'b0, '0);
				end else if (roll < 30) begin
					it.cmd = CMD_WRITE;
					pos = pick_pos(w, hot_c);
					it.col_a = POS_W'((pos > w - 1) ? w - 1 : pos);
					pos = pick_pos(h, hot_r);
					it.row_a = POS_W'((pos > h - 1) ? h - 1 : pos);
					issue(it, 1'b0, '0);
				end else if (roll < 65) begin
					it.cmd = CMD_WINDOW;
					it.col_a = POS_W'(pick_pos(w, hot_c));
					it.row_a = POS_W'(pick_pos(h, hot_r));
					it.col_b = POS_W'(far_corner(int'(it.col_a)));
					it.row_b = POS_W'(far_corner(int'(it.row_a)));
					if (window_span(it, x0, x1, y0, y1)) cover_region(x0, x1, y0, y1);
					issue(it, 1'b0, '0);
				end else begin
					it.cmd = CMD_SAMPLE;
					it.sample_x = SAMPLE_W'(sample_coord(w, hot_c));
					it.sample_y = SAMPLE_W'(sample_coord(h, hot_r));
					sample_corners(it, ix, ix2, iy, iy2, fx, fy);
					cover_region(ix, ix2, iy, iy2);
					issue(it, 1'b0, '0);
				end
				// hold until every awaited result is back
				if ($urandom_range(0, 99) == 0) drain();
			end
		end

		drain();
		$display("run: %0d items over %0d map sizes, %0d texel writes", items_done, PHASES + 2,
			texel_writes);
		$display("run: %0d window queries (%0d empty), %0d bilinear samples", window_queries,
			empty_windows, sample_queries);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/hbs_pkg.sv
rtl/hbs_if.sv
rtl/hbs_interp.sv
rtl/heightmap_bounds_and_bilinear_sampler_unit.sv
tb/testbench.sv
